// ===== rtl/core/rsdl_pkg.sv =====
// rsdl_pkg: shared types, opcodes and the address folding function for the
// sorted device list. No dependencies.
package rsdl_pkg;

  localparam int KEY_W  = 28;
  localparam int MAC_W  = 48;
  localparam int RSSI_W = 8;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  // Read window size follows from the read index width.
  localparam int RD_WIN = 1 << IDX_W;

  localparam logic [7:0] HI_NIB = 8'hF0;
  localparam logic [7:0] LO_NIB = 8'h0F;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_REMOVE = 2'd1,
    CELL_PLACE  = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] rssi;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    ent;
  } cell_ctl_t;

  // Per-cell compare status back to the controller.
  typedef struct packed {
    logic match;
    logic same;
  } cell_stat_t;

  // Fold the address: top nibble is byte 5's high nibble, bottom nibble is
  // byte 0's low nibble, each other is a byte's low XOR the byte below's high.
  function automatic logic [KEY_W-1:0] make_key(input logic [MAC_W-1:0] mac);
    logic [KEY_W-1:0] key;
    logic [7:0]       lo_b;
    logic [7:0]       hi_b;
    key = '0;
    key[KEY_W-1 -: 4] = 4'((mac[47:40] & HI_NIB) >> 4);
    for (int i = 1; i < 6; i++) begin
      lo_b = mac[8*i +: 8] & LO_NIB;
      hi_b = (mac[8*(i-1) +: 8] & HI_NIB) >> 4;
      key[4*i +: 4] = lo_b[3:0] ^ hi_b[3:0];
    end
    lo_b = mac[7:0] & LO_NIB;
    key[3:0] = lo_b[3:0];
    return key;
  endfunction

endpackage

// ===== rtl/core/rsdl_cell.sv =====
// rsdl_cell: one list slot. Compares its entry against the broadcast entry and
// shifts towards either neighbour on remove or place. Depends on rsdl_pkg.
module rsdl_cell (
  input  logic                clk,
  input  rsdl_pkg::cell_ctl_t ctl,
  input  logic                live,
  input  rsdl_pkg::entry_t    from_up,
  input  rsdl_pkg::entry_t    from_dn,
  input  logic                rm_in,
  input  logic                after_in,
  output rsdl_pkg::entry_t    q,
  output logic                rm_out,
  output logic                after_out,
  output rsdl_pkg::cell_stat_t stat
);

  logic match;
  logic after;

  assign match      = live && (q.key == ctl.ent.key);
  assign stat       = '{match: match, same: match && (q.rssi == ctl.ent.rssi)};
  assign rm_out     = rm_in | match;
  // New entry belongs at or before this slot.
  assign after      = !live || ($signed(q.rssi) <= $signed(ctl.ent.rssi));
  assign after_out  = after;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      rsdl_pkg::CELL_REMOVE: begin
        if (rm_out) begin
          q <= from_up;
        end
      end
      rsdl_pkg::CELL_PLACE: begin
        if (after && after_in) begin
          q <= from_dn;
        end else if (after) begin
          q <= ctl.ent;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// ===== rtl/core/rssi_sorted_device_list.sv =====
// rssi_sorted_device_list: sequencer, fill count and result register around a
// row of rsdl_cell slots. Depends on rsdl_pkg and rsdl_cell.
// Insert: remove pass, place pass and result load from input transfer to
// result valid, with the place pass skipped when the same device repeats at
// the same strength; read, clear and no-op go straight to the result load.
// A new item is taken only once the sequencer is back in idle; a stalled
// result holds the input off. Reset empties the list and drops any pending
// result; slot contents are not cleared.
module rssi_sorted_device_list #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rsdl_pkg::OP_W-1:0]           opcode,
  input  logic [rsdl_pkg::MAC_W-1:0]          device_mac,
  input  logic signed [rsdl_pkg::RSSI_W-1:0]  signal_strength,
  input  logic [rsdl_pkg::IDX_W-1:0]          read_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                entry_valid,
  output logic [rsdl_pkg::MAC_W-1:0]          entry_mac,
  output logic signed [rsdl_pkg::RSSI_W-1:0]  entry_rssi,
  output logic [rsdl_pkg::CNT_W-1:0]          list_count,
  output logic                                tail_dropped
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_PLACE,
    S_EMIT
  } state_t;

  state_t                          state;
  rsdl_pkg::opcode_t               op;
  rsdl_pkg::entry_t                new_ent;
  logic [rsdl_pkg::IDX_W-1:0]      rd_idx;
  logic [CW-1:0]                   count;
  logic                            ins_drop;

  rsdl_pkg::cell_ctl_t             ctl;
  rsdl_pkg::entry_t                cell_q   [DEPTH];
  rsdl_pkg::cell_stat_t            cell_st  [DEPTH];
  logic [DEPTH-1:0]                live;
  logic [DEPTH-1:0]                rm_c;
  logic [DEPTH-1:0]                after_c;
  logic [DEPTH-1:0]                match_v;
  logic [DEPTH-1:0]                same_v;
  rsdl_pkg::entry_t                rd_win   [rsdl_pkg::RD_WIN];
  logic                            rd_hit;
  logic                            rd_ok;
  logic                            full;
  logic [CW+rsdl_pkg::CNT_W-1:0]   cnt_ext;

  assign in_stall = (state != S_IDLE);
  assign full     = (count == CW'(DEPTH));

  always_comb begin
    ctl.ent = new_ent;
    case (state)
      S_REMOVE: ctl.cmd = (|same_v) ? rsdl_pkg::CELL_HOLD : rsdl_pkg::CELL_REMOVE;
      S_PLACE:  ctl.cmd = rsdl_pkg::CELL_PLACE;
      default:  ctl.cmd = rsdl_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign live[i]    = (count > CW'(i));
    assign match_v[i] = cell_st[i].match;
    assign same_v[i]  = cell_st[i].same;

    rsdl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (live[i]),
      .from_up   (cell_q[(i + 1 < DEPTH) ? i + 1 : i]),
      .from_dn   (cell_q[(i > 0) ? i - 1 : i]),
      .rm_in     ((i > 0) ? rm_c[(i > 0) ? i - 1 : 0] : 1'b0),
      .after_in  ((i > 0) ? after_c[(i > 0) ? i - 1 : 0] : 1'b0),
      .q         (cell_q[i]),
      .rm_out    (rm_c[i]),
      .after_out (after_c[i]),
      .stat      (cell_st[i])
    );
  end

  for (genvar r = 0; r < rsdl_pkg::RD_WIN; r++) begin : g_rd
    if (r < DEPTH) begin : g_slot
      assign rd_win[r] = cell_q[r];
    end else begin : g_pad
      assign rd_win[r] = '0;
    end
  end

  assign rd_hit  = ({{CW{1'b0}}, rd_idx} < {{rsdl_pkg::IDX_W{1'b0}}, count});
  assign rd_ok   = (op == rsdl_pkg::OP_READ) && rd_hit;
  assign cnt_ext = {{rsdl_pkg::CNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= rsdl_pkg::opcode_t'(opcode);
            new_ent.key <= rsdl_pkg::make_key(device_mac);
            new_ent.mac <= device_mac;
            new_ent.rssi <= signal_strength;
            rd_idx      <= read_index;
            ins_drop    <= 1'b0;
            state       <= (rsdl_pkg::opcode_t'(opcode) == rsdl_pkg::OP_INSERT) ?
                           S_REMOVE : S_EMIT;
          end
        end
        S_REMOVE: begin
          // Same key with same strength: leave the list alone.
          if (|same_v) begin
            state <= S_EMIT;
          end else begin
            if (|match_v) begin
              count <= count - CW'(1);
            end
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          ins_drop <= full;
          if (!full) begin
            count <= count + CW'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            entry_valid  <= rd_ok;
            entry_mac    <= rd_ok ? rd_win[rd_idx].mac : '0;
            entry_rssi   <= rd_ok ? rd_win[rd_idx].rssi : '0;
            tail_dropped <= (op == rsdl_pkg::OP_INSERT) && ins_drop;
            if (op == rsdl_pkg::OP_CLEAR) begin
              count      <= '0;
              list_count <= '0;
            end else begin
              list_count <= cnt_ext[rsdl_pkg::CNT_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
